// File: hw/rtl/wla_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wla_pkg
// Shared sizes, operation codes and transfer types of the weighted lottery
// arbiter.
// ----------------------------------------------------------------------------
package wla_pkg;

    // Sizing of the requester table
    localparam int NUM_INPUTS  = 16;
    localparam int WEIGHT_BITS = 8;
    localparam int ID_BITS     = 16;

    localparam int IDX_W   = $clog2(NUM_INPUTS);
    // Running total must hold every requester at full weight
    localparam int TOTAL_W = $clog2(NUM_INPUTS * ((2 ** WEIGHT_BITS) - 1) + 1);
    localparam int RND_W   = 16;

    // Operation codes
    localparam logic [1:0] FUNC_POST  = 2'd0;
    localparam logic [1:0] FUNC_ARB   = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    // Input transfer
    typedef struct packed {
        logic [1:0]  func;
        logic [3:0]  requester;
        logic [15:0] request_id;
        logic [7:0]  request_weight;
        logic [15:0] random_value;
    } wla_in_t;

    // Result transfer
    typedef struct packed {
        logic        grant_valid;
        logic [3:0]  granted_requester;
        logic [15:0] granted_id;
        logic [7:0]  granted_weight;
    } wla_out_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic post;
        logic clear;
        logic start;
        logic step;
        logic emit;
    } wla_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [1:0] func;
        logic       total_zero;
        logic       hit;
        logic       last;
        logic       out_free;
    } wla_stat_t;

endpackage

// File: hw/rtl/wla_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wla_datapath
// Request table, running total, scaled choice, weight scan and the result
// output register.
// ----------------------------------------------------------------------------
module wla_datapath import wla_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  wla_in_t   s_data,
    input  wla_cmd_t  cmd,
    output wla_stat_t stat,
    output logic      m_valid,
    input  logic      m_ready,
    output wla_out_t  m_data
);

    // Held item
    wla_in_t item_reg;

    // Request table
    logic [NUM_INPUTS-1:0]  present_reg;
    logic [ID_BITS-1:0]     ident_reg [NUM_INPUTS];
    logic [WEIGHT_BITS-1:0] wt_reg    [NUM_INPUTS];
    logic [TOTAL_W-1:0]     total_reg;

    // Scan state
    logic [TOTAL_W-1:0]     choice_reg;
    logic [TOTAL_W-1:0]     sum_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic                   found_reg;
    logic [IDX_W-1:0]       win_idx_reg;
    logic [ID_BITS-1:0]     win_id_reg;
    logic [WEIGHT_BITS-1:0] win_wt_reg;

    // Output register
    logic     m_valid_reg;
    wla_out_t res_reg;

    // Table read port
    logic [IDX_W-1:0]       req_idx;
    logic [IDX_W-1:0]       rd_idx;
    logic                   rd_present;
    logic [ID_BITS-1:0]     rd_id;
    logic [WEIGHT_BITS-1:0] rd_wt;

    // Post and scan arithmetic
    logic [WEIGHT_BITS-1:0]   new_wt;
    logic [ID_BITS-1:0]       new_id;
    logic                     post_ok;
    logic [TOTAL_W-1:0]       total_next;
    logic [TOTAL_W-1:0]       sum_next;
    logic [RND_W+TOTAL_W-1:0] product;
    logic                     hit;
    wla_out_t                 res_next;

    // Share one read address between post and scan
    assign req_idx    = IDX_W'(item_reg.requester);
    assign rd_idx     = cmd.post ? req_idx : idx_reg;
    assign rd_present = present_reg[rd_idx];
    assign rd_id      = ident_reg[rd_idx];
    assign rd_wt      = wt_reg[rd_idx];

    // Decide whether a post lands
    assign new_wt  = WEIGHT_BITS'(item_reg.request_weight);
    assign new_id  = ID_BITS'(item_reg.request_id);
    assign post_ok = (new_wt != '0) && (int'(item_reg.requester) < NUM_INPUTS)
                     && (!rd_present || (rd_wt < new_wt));

    // Replace the old weight in the running total
    always_comb begin
        total_next = total_reg + TOTAL_W'(new_wt);
        if (rd_present) begin
            total_next = total_next - TOTAL_W'(rd_wt);
        end
    end

    // Scale random value into a choice below the total
    assign product  = (RND_W + TOTAL_W)'(item_reg.random_value)
                      * (RND_W + TOTAL_W)'(total_reg);
    assign sum_next = sum_reg + TOTAL_W'(rd_wt);
    assign hit      = rd_present && (sum_next > choice_reg);

    // Status back to the controller
    assign stat.func       = item_reg.func;
    assign stat.total_zero = (total_reg == '0);
    assign stat.hit        = hit;
    assign stat.last       = (idx_reg == IDX_W'(NUM_INPUTS - 1));
    assign stat.out_free   = !m_valid_reg || m_ready;

    // Hold item and scan payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= s_data;
        end
        if (cmd.start) begin
            choice_reg <= TOTAL_W'(product >> RND_W);
            sum_reg    <= '0;
            idx_reg    <= '0;
        end else if (cmd.step && !hit) begin
            if (rd_present) begin
                sum_reg <= sum_next;
            end
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.step && hit) begin
            win_idx_reg <= idx_reg;
            win_id_reg  <= rd_id;
            win_wt_reg  <= rd_wt;
        end
    end

    // Write identifier and weight of a landed post
    always_ff @(posedge aclk) begin
        if (cmd.post && post_ok) begin
            ident_reg[req_idx] <= new_id;
            wt_reg[req_idx]    <= new_wt;
        end
    end

    // Presence, total and winner flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_reg <= '0;
            total_reg   <= '0;
            found_reg   <= 1'b0;
        end else begin
            if (cmd.clear) begin
                present_reg <= '0;
                total_reg   <= '0;
            end else if (cmd.post && post_ok) begin
                present_reg[req_idx] <= 1'b1;
                total_reg            <= total_next;
            end
            if (cmd.load) begin
                found_reg <= 1'b0;
            end else if (cmd.step && hit) begin
                found_reg <= 1'b1;
            end
        end
    end

    // Build the result; no winner gives all zero
    always_comb begin
        res_next = '0;
        if (found_reg) begin
            res_next.grant_valid       = 1'b1;
            res_next.granted_requester = 4'(win_idx_reg);
            res_next.granted_id        = 16'(win_id_reg);
            res_next.granted_weight    = 8'(win_wt_reg);
        end
    end

    // Output register: load on emit, drop once the transfer completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            res_reg <= res_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = res_reg;

    // Total is zero exactly when no request is held
    a_total_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (total_reg == '0) == (present_reg == '0))
        else $error("total weight disagrees with request presence");

    // Never overwrite a result that has not been taken
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_valid_reg || m_ready))
        else $error("result emitted over a pending transfer");

    // A granted request carries a nonzero weight
    a_grant_wt: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && res_reg.grant_valid) |-> (res_reg.granted_weight != '0))
        else $error("grant with zero weight");

endmodule

// File: hw/rtl/wla_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wla_ctrl
// Sequencer for the lottery arbiter: accept, decode, scan, emit.
// ----------------------------------------------------------------------------
module wla_ctrl import wla_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  wla_stat_t stat,
    output wla_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;

    // Commands and next state
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && ready_reg) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                state_next = ST_EMIT;
                if (stat.func == FUNC_POST) begin
                    cmd.post = 1'b1;
                end else if (stat.func == FUNC_CLEAR) begin
                    cmd.clear = 1'b1;
                end else if (stat.func == FUNC_ARB && !stat.total_zero) begin
                    cmd.start  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.step = 1'b1;
                if (stat.hit || stat.last) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and the registered ready
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ready_reg <= (state_next == ST_IDLE) && !cmd.load;
        end
    end

    assign s_ready = ready_reg;

    // Ready only while waiting for an item
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ready_reg |-> (state_reg == ST_IDLE))
        else $error("ready outside idle");

    // An accepted item is decoded next
    a_accept_decode: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && ready_reg) |=> (state_reg == ST_DECODE))
        else $error("accepted item not decoded");

    // Scan starts only with requests present
    a_start_total: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |-> !stat.total_zero)
        else $error("scan started on empty table");

endmodule

// File: hw/rtl/weighted_lottery_arbiter.sv
`timescale 1ns / 1ps
// Post, clear, unused codes and arbitrate on an empty table pass from decode straight to
// emit. Arbitrate otherwise scans the table from index 0 up to the winner's entry (or the
// last entry) before emit. A new item is taken only after the last result has been
// loaded into the output register; the scan reads one table entry per cycle and a result
// held by the receiver holds the next input.
// Reset (aresetn, synchronous, low) drops all requests and the pending result.
// ----------------------------------------------------------------------------
// weighted_lottery_arbiter
// Lottery arbiter: weighted requests are posted, then a random value picks a
// winner in proportion to its weight.
// ----------------------------------------------------------------------------
module weighted_lottery_arbiter import wla_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  wla_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output wla_out_t m_data
);

    wla_cmd_t  cmd;
    wla_stat_t stat;

    // Sequencer
    wla_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Table, scan and result register
    wla_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// File: tb/sv/weighted_lottery_arbiter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_lottery_arbiter_tb
// Self-checking bench for the lottery arbiter. It drives posts, arbitrations,
// clears and the unused code through the input channel. Sender bursts and
// receiver stalls vary at random. A grant table mirrors the block's state, and
// every result transfer is compared field by field with the oldest predicted
// grant.
// ----------------------------------------------------------------------------
module weighted_lottery_arbiter_tb import wla_pkg::*; ();

    localparam int RANDOM_ITEMS = 1850;
    localparam int DRAIN_CYCLES = 60;
    localparam int REPORT_LIMIT = 10;

    // Operation code with no function
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    typedef enum int {
        RX_FREE,
        RX_COIN,
        RX_SPARSE,
        RX_PATTERN
    } rx_mode_t;

    // Mirror of the requester table; predicts one result per transfer
    class grant_scoreboard;
        bit                     present [NUM_INPUTS];
        bit [ID_BITS-1:0]       ident   [NUM_INPUTS];
        bit [WEIGHT_BITS-1:0]   weight  [NUM_INPUTS];
        bit [TOTAL_W-1:0]       total;
        wla_out_t               expected_grants [$];
        int                     failures;

        function new();
            foreach (present[k]) begin
                present[k] = 1'b0;
                ident[k]   = '0;
                weight[k]  = '0;
            end
            total    = '0;
            failures = 0;
        endfunction

        // Apply one accepted input transfer and queue the grant it causes
        function void predict_grant(wla_in_t item);
            wla_out_t    res;
            int unsigned choice;
            int unsigned sum;
            bit          found;
            int          who;
            res   = '0;
            sum   = 0;
            found = 1'b0;
            who   = int'(item.requester);
            case (item.func)
                FUNC_POST: begin
                    // Keep an existing request unless the new weight is higher
                    if (item.request_weight != '0 && who < NUM_INPUTS &&
                        (!present[who] || weight[who] < item.request_weight)) begin
                        if (present[who])
                            total = total - TOTAL_W'(weight[who]);
                        total        = total + TOTAL_W'(item.request_weight);
                        present[who] = 1'b1;
                        ident[who]   = item.request_id;
                        weight[who]  = item.request_weight;
                    end
                end
                FUNC_CLEAR: begin
                    foreach (present[k])
                        present[k] = 1'b0;
                    total = '0;
                end
                FUNC_ARB: begin
                    // Scale the random value below the total, then scan from index 0
                    if (total != '0) begin
                        choice = (int'(item.random_value) * int'(total)) >> RND_W;
                        for (int k = 0; k < NUM_INPUTS; k++) begin
                            if (present[k] && !found) begin
                                sum = sum + int'(weight[k]);
                                if (sum > choice) begin
                                    found                 = 1'b1;
                                    res.grant_valid       = 1'b1;
                                    res.granted_requester = 4'(k);
                                    res.granted_id        = ident[k];
                                    res.granted_weight    = weight[k];
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase
            expected_grants.push_back(res);
        endfunction

        // Compare one result transfer with the oldest predicted grant
        function void check_grant(wla_out_t got);
            wla_out_t want;
            bit       bad;
            if (expected_grants.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("[%0t] unexpected result transfer: got %h", $realtime, got);
            end else begin
                want = expected_grants.pop_front();
                bad  = (got.grant_valid       !== want.grant_valid) ||
                       (got.granted_requester !== want.granted_requester) ||
                       (got.granted_id        !== want.granted_id) ||
                       (got.granted_weight    !== want.granted_weight);
                if (bad) begin
                    failures++;
                    if (failures <= REPORT_LIMIT)
                        $display({"[%0t] grant mismatch: expected v=%0b req=%0d id=%h wt=%h,",
                                  " got v=%0b req=%0d id=%h wt=%h"}, $realtime,
                                 want.grant_valid, want.granted_requester,
                                 want.granted_id, want.granted_weight,
                                 got.grant_valid, got.granted_requester,
                                 got.granted_id, got.granted_weight);
                end
            end
        endfunction

        function int pending();
            return expected_grants.size();
        endfunction
    endclass

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    wla_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    wla_out_t m_data;

    grant_scoreboard sb = new();

    int       burst_left = 0;
    rx_mode_t rx_mode    = RX_FREE;
    int       rx_left    = 0;
    bit [15:0] rx_pattern = '1;

    weighted_lottery_arbiter dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Check result transfers and stall the result channel in a mode that changes at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready)
                sb.check_grant(m_data);
            if (rx_left == 0) begin
                rx_mode    = rx_mode_t'($urandom_range(0, 3));
                rx_left    = $urandom_range(50, 400);
                rx_pattern = 16'($urandom);
            end else begin
                rx_left--;
            end
            case (rx_mode)
                RX_FREE:    m_ready <= 1'b1;
                RX_COIN:    m_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE:  m_ready <= ($urandom_range(0, 7) == 0);
                default: begin
                    m_ready    <= rx_pattern[0];
                    rx_pattern  = {rx_pattern[0], rx_pattern[15:1]};
                end
            endcase
        end
    end

    function automatic wla_in_t make_item(logic [1:0] func, int who, int id, int wt, int rnd);
        wla_in_t item;
        item.func           = func;
        item.requester      = 4'(who);
        item.request_id     = 16'(id);
        item.request_weight = 8'(wt);
        item.random_value   = 16'(rnd);
        return item;
    endfunction

    // Present one item, hold it until transfer, then pace the next burst
    task automatic send_item(input wla_in_t item);
        int gap;
        s_data  <= item;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sb.predict_grant(item);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end else begin
            burst_left--;
        end
    endtask

    // Run timeout
    initial begin
        #6_000_000;
        $display("FAIL weighted_lottery_arbiter");
        $finish;
    end

    initial begin
        wla_in_t item;
        int      counted;
        int      pick;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty table, zero weight, extremes, replacement rules, clear
        send_item(make_item(FUNC_ARB,   0, 'h0000, 0,    'hFFFF));
        send_item(make_item(FUNC_POST,  3, 'h1234, 0,    'h0000));
        send_item(make_item(FUNC_ARB,   0, 'h0000, 0,    'h0000));
        send_item(make_item(FUNC_POST,  0, 'hFFFF, 'hFF, 'hFFFF));
        send_item(make_item(FUNC_POST, 15, 'h0000, 1,    'h0000));
        send_item(make_item(FUNC_ARB,   0, 'h0000, 0,    'h0000));
        send_item(make_item(FUNC_ARB,  15, 'hFFFF, 'hFF, 'hFFFF));
        send_item(make_item(FUNC_POST,  0, 'h0101, 'h80, 'h0000));
        send_item(make_item(FUNC_POST,  0, 'h0202, 'hFF, 'h0000));
        send_item(make_item(FUNC_POST, 15, 'hA5A5, 2,    'h0000));
        send_item(make_item(FUNC_POST,  7, 'h5A5A, 'h7F, 'h0000));
        send_item(make_item(FUNC_ARB,   0, 'h0000, 0,    'hFFFF));
        send_item(make_item(FUNC_ARB,   0, 'h0000, 0,    'h8000));
        send_item(make_item(FUNC_ARB,   0, 'h0000, 0,    'h8000));
        send_item(make_item(FUNC_UNUSED, 15, 'hFFFF, 'hFF, 'hFFFF));
        send_item(make_item(FUNC_ARB,   0, 'h0000, 0,    'h0001));
        send_item(make_item(FUNC_CLEAR, 0, 'h0000, 0,    'h0000));
        send_item(make_item(FUNC_ARB,   0, 'h0000, 0,    'h4000));
        send_item(make_item(FUNC_POST,  0, 'h00FF, 1,    'h0000));
        send_item(make_item(FUNC_ARB,   0, 'h0000, 0,    'hFFFF));
        send_item(make_item(FUNC_CLEAR, 0, 'h0000, 0,    'h0000));

        // Random: mostly posts and arbitrations, rare clears and unused codes
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            item = wla_in_t'(($bits(wla_in_t))'({$urandom, $urandom}));
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                item.func = FUNC_CLEAR;
            end else if (pick < 5) begin
                item.func = FUNC_UNUSED;
            end else if (pick < 52) begin
                item.func = FUNC_POST;
                case ($urandom_range(0, 9))
                    0:       item.request_weight = '0;
                    1, 2:    item.request_weight = '1;
                    3:       item.request_weight = 8'($urandom_range(1, 4));
                    default: item.request_weight = 8'($urandom_range(1, 255));
                endcase
            end else begin
                item.func = FUNC_ARB;
                case ($urandom_range(0, 15))
                    0:       item.random_value = '0;
                    1:       item.random_value = '1;
                    default: ;
                endcase
            end
            counted++;
            send_item(item);
        end
        s_valid <= 1'b0;

        // Drain outstanding grants, then watch for stray results
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.failures == 0)
            $display("PASS weighted_lottery_arbiter");
        else
            $display("FAIL weighted_lottery_arbiter");
        $finish;
    end

endmodule
